/* sv/pcivt_pkg.sv */
// ----------------------------------------------------------------------------
// pcivt_pkg
// Shared types, codes and constants of the per-CPU interrupt vector table.
// ----------------------------------------------------------------------------
package pcivt_pkg;

   // default sizes
   localparam int CPU_COUNT_DEF       = 256;
   localparam int VECTORS_PER_CPU_DEF = 128;
   localparam int HANDLER_ID_BITS_DEF = 16;

   // field widths
   localparam int CPU_W    = 8;
   localparam int ID_W     = 16;
   localparam int VEC_W    = 8;
   localparam int PRIV_W   = 2;
   localparam int GRANT_W  = 7;
   localparam int FFV_W    = 7;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // architectural constants
   localparam int FIRST_IRQ_VECTOR  = 32;
   localparam int TIMER_VECTOR      = 32;
   localparam int PAGE_FAULT_VECTOR = 14;
   localparam int USER_PRIV         = 3;
   localparam int RESET_FIRST_FREE  = 48;

   // free search granularity
   localparam int GROUP_BITS = 16;

   // register index of first_free_vector
   localparam logic REG_FIRST_FREE = 1'b0;

   typedef enum logic [1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_FREE     = 2'd1,
      CMD_MOVE     = 2'd2,
      CMD_DISPATCH = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_FATAL     = 3'd0,
      ACT_USER_PF   = 3'd1,
      ACT_TIMER     = 3'd2,
      ACT_HANDLER   = 3'd3,
      ACT_UNHANDLED = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_OLD_READ,
      ST_OLD_CLEAR,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic pick;
      logic rel_cur;
      logic old_read;
      logic old_clear;
      logic emit;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    grant_ok;
      logic    old_valid;
      logic    out_free;
   } sts_type;

endpackage

/* sv/pcivt_if.sv */
// ----------------------------------------------------------------------------
// pcivt_req_if / pcivt_rsp_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface pcivt_req_if;
   logic                              valid;
   logic                              ready;
   pcivt_pkg::cmd_type                command;
   logic [pcivt_pkg::CPU_W-1:0]       cpu;
   logic [pcivt_pkg::ID_W-1:0]        handler_id;
   logic [pcivt_pkg::VEC_W-1:0]       vector;
   logic [pcivt_pkg::CPU_W-1:0]       old_cpu;
   logic                              old_valid;
   logic [pcivt_pkg::PRIV_W-1:0]      privilege;

   modport source (output valid, command, cpu, handler_id, vector, old_cpu, old_valid,
                   privilege, input ready);
   modport sink   (input valid, command, cpu, handler_id, vector, old_cpu, old_valid,
                   privilege, output ready);
endinterface

interface pcivt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              ok;
   logic [pcivt_pkg::GRANT_W-1:0]     granted_vector;
   logic [pcivt_pkg::ID_W-1:0]        found_handler;
   pcivt_pkg::action_type             action;

   modport source (output valid, ok, granted_vector, found_handler, action, input ready);
   modport sink   (input valid, ok, granted_vector, found_handler, action, output ready);
endinterface

/* sv/per_cpu_interrupt_vector_table_top.sv */
// ----------------------------------------------------------------------------
// per_cpu_interrupt_vector_table_top
// Per-CPU interrupt vector allocator with free, move and dispatch lookup.
// ----------------------------------------------------------------------------
// Items enter on req_ch (valid/ready) and each returns exactly one result item
// on rsp_ch. The APB port sets the lowest allocatable vector (values below 32
// act as 32); write it only while the block is idle.
// One item is worked at a time; each step reads or rewrites one occupancy
// row in a single-port row memory, and that memory sets the pace:
//   dispatch, free : accept and row read, scan, finish
//   alloc, move    : accept and row read, scan, pick, finish
//   move, old vector freed: accept, scan, pick, old read, old clear, finish
// The free-vector search takes two steps: mask per row in the scan step, then
// group and bit priority pick in the pick step.
// Reset clears the per-row valid flags at once, so every vector reads as free
// right away; there is no clearing pass. Handler ids are only reported for
// vectors whose occupancy bit is set.
// A finished result waits in the output register while rsp_ch is stalled; a
// new item is still accepted, and its result is held back until the register
// frees up.
// ----------------------------------------------------------------------------
module per_cpu_interrupt_vector_table_top #(
   parameter int CPU_COUNT       = pcivt_pkg::CPU_COUNT_DEF,
   parameter int VECTORS_PER_CPU = pcivt_pkg::VECTORS_PER_CPU_DEF,
   parameter int HANDLER_ID_BITS = pcivt_pkg::HANDLER_ID_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pcivt_req_if.sink                        req_ch,
   pcivt_rsp_if.source                      rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pcivt_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [pcivt_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [pcivt_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                             csr_pready
);

   pcivt_pkg::ctl_type           ctl;
   pcivt_pkg::sts_type           sts;
   logic [pcivt_pkg::FFV_W-1:0]  first_free;
   logic                         req_ready;

   assign req_ch.ready = req_ready;

   pcivt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .first_free  (first_free)
   );

   pcivt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   pcivt_dpath #(
      .CPU_COUNT       (CPU_COUNT),
      .VECTORS_PER_CPU (VECTORS_PER_CPU),
      .HANDLER_ID_BITS (HANDLER_ID_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .first_free         (first_free),
      .req_command        (req_ch.command),
      .req_cpu            (req_ch.cpu),
      .req_handler_id     (req_ch.handler_id),
      .req_vector         (req_ch.vector),
      .req_old_cpu        (req_ch.old_cpu),
      .req_old_valid      (req_ch.old_valid),
      .req_privilege      (req_ch.privilege),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ok             (rsp_ch.ok),
      .rsp_granted_vector (rsp_ch.granted_vector),
      .rsp_found_handler  (rsp_ch.found_handler),
      .rsp_action         (rsp_ch.action)
   );

endmodule

/* sv/pcivt_csr.sv */
// ----------------------------------------------------------------------------
// pcivt_csr
// APB register slice holding the lowest allocatable vector.
// ----------------------------------------------------------------------------
module pcivt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pcivt_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [pcivt_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [pcivt_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                             csr_pready,
   output logic [pcivt_pkg::FFV_W-1:0]      first_free
);

   logic [pcivt_pkg::FFV_W-1:0] first_free_ff;
   logic [pcivt_pkg::FFV_W-1:0] first_free_in;
   logic                        hit;

   assign hit = (csr_paddr[2] == pcivt_pkg::REG_FIRST_FREE);

   always_comb begin
      first_free_in = first_free_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         first_free_in = csr_pwdata[pcivt_pkg::FFV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_free_ff <= pcivt_pkg::FFV_W'(pcivt_pkg::RESET_FIRST_FREE);
      end else begin
         first_free_ff <= first_free_in;
      end
   end

   assign csr_prdata = hit ? pcivt_pkg::CSR_DW'(first_free_ff) : '0;
   assign csr_pready = 1'b1;
   assign first_free = first_free_ff;

endmodule

/* sv/pcivt_ctrl.sv */
// ----------------------------------------------------------------------------
// pcivt_ctrl
// Sequencer: accept, scan row, commit grant, free old vector, deliver result.
// ----------------------------------------------------------------------------
module pcivt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pcivt_pkg::sts_type    sts,
   output pcivt_pkg::ctl_type    ctl
);

   pcivt_pkg::state_type state_ff;
   pcivt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcivt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pcivt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = pcivt_pkg::ST_SCAN;
            end
         end
         pcivt_pkg::ST_SCAN: begin
            ctl.scan = 1'b1;
            unique case (sts.cmd)
               pcivt_pkg::CMD_ALLOC,
               pcivt_pkg::CMD_MOVE: state_in = pcivt_pkg::ST_PICK;
               pcivt_pkg::CMD_FREE: begin
                  ctl.rel_cur = 1'b1;
                  state_in    = pcivt_pkg::ST_FINISH;
               end
               default: state_in = pcivt_pkg::ST_FINISH;
            endcase
         end
         pcivt_pkg::ST_PICK: begin
            ctl.pick = 1'b1;
            // only a successful move frees its old vector
            if (sts.cmd == pcivt_pkg::CMD_MOVE && sts.grant_ok && sts.old_valid) begin
               state_in = pcivt_pkg::ST_OLD_READ;
            end else begin
               state_in = pcivt_pkg::ST_FINISH;
            end
         end
         pcivt_pkg::ST_OLD_READ: begin
            ctl.old_read = 1'b1;
            state_in     = pcivt_pkg::ST_OLD_CLEAR;
         end
         pcivt_pkg::ST_OLD_CLEAR: begin
            ctl.old_clear = 1'b1;
            state_in      = pcivt_pkg::ST_FINISH;
         end
         pcivt_pkg::ST_FINISH: begin
            // hold until the output register can take the item
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               state_in = pcivt_pkg::ST_IDLE;
            end
         end
         default: state_in = pcivt_pkg::ST_IDLE;
      endcase
   end

endmodule

/* sv/pcivt_dpath.sv */
// ----------------------------------------------------------------------------
// pcivt_dpath
// Occupancy row memory, handler memory, free-vector search and result register.
// ----------------------------------------------------------------------------
module pcivt_dpath #(
   parameter int CPU_COUNT       = pcivt_pkg::CPU_COUNT_DEF,
   parameter int VECTORS_PER_CPU = pcivt_pkg::VECTORS_PER_CPU_DEF,
   parameter int HANDLER_ID_BITS = pcivt_pkg::HANDLER_ID_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pcivt_pkg::ctl_type                ctl,
   output pcivt_pkg::sts_type                sts,
   input  logic [pcivt_pkg::FFV_W-1:0]       first_free,
   input  pcivt_pkg::cmd_type                req_command,
   input  logic [pcivt_pkg::CPU_W-1:0]       req_cpu,
   input  logic [pcivt_pkg::ID_W-1:0]        req_handler_id,
   input  logic [pcivt_pkg::VEC_W-1:0]       req_vector,
   input  logic [pcivt_pkg::CPU_W-1:0]       req_old_cpu,
   input  logic                              req_old_valid,
   input  logic [pcivt_pkg::PRIV_W-1:0]      req_privilege,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_ok,
   output logic [pcivt_pkg::GRANT_W-1:0]     rsp_granted_vector,
   output logic [pcivt_pkg::ID_W-1:0]        rsp_found_handler,
   output pcivt_pkg::action_type             rsp_action
);

   localparam int CPU_AW    = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
   localparam int OCC_DEPTH = 1 << CPU_AW;
   localparam int VEC_AW    = $clog2(VECTORS_PER_CPU);
   localparam int HT_AW     = CPU_AW + VEC_AW;
   localparam int HT_DEPTH  = 1 << HT_AW;
   localparam int GB        = pcivt_pkg::GROUP_BITS;
   localparam int BIT_AW    = $clog2(GB);
   localparam int NG        = (VECTORS_PER_CPU + GB - 1) / GB;
   localparam int GRP_AW    = (NG > 1) ? $clog2(NG) : 1;
   localparam int PAD       = NG * GB;
   localparam int GNT_W     = GRP_AW + BIT_AW;

   // latched item
   pcivt_pkg::cmd_type            cmd_ff;
   logic [pcivt_pkg::CPU_W-1:0]   cpu_ff;
   logic [pcivt_pkg::ID_W-1:0]    hid_ff;
   logic [pcivt_pkg::VEC_W-1:0]   vec_ff;
   logic [pcivt_pkg::CPU_W-1:0]   old_cpu_ff;
   logic                          old_valid_ff;
   logic [pcivt_pkg::PRIV_W-1:0]  priv_ff;

   // memories
   logic [VECTORS_PER_CPU-1:0]    occ_mem [OCC_DEPTH];
   logic [HANDLER_ID_BITS-1:0]    hnd_mem [HT_DEPTH];
   logic                          row_valid_ff [OCC_DEPTH];
   logic [VECTORS_PER_CPU-1:0]    row_raw_ff;
   logic                          rd_valid_ff;
   logic [HANDLER_ID_BITS-1:0]    hd_ff;

   // search and result
   logic [PAD-1:0]                free_bits_ff;
   logic                          ok_ff;
   logic [pcivt_pkg::GRANT_W-1:0] granted_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_ok_ff;
   logic [pcivt_pkg::GRANT_W-1:0] rsp_granted_ff;
   logic [pcivt_pkg::ID_W-1:0]    rsp_found_ff;
   pcivt_pkg::action_type         rsp_action_ff;

   logic [PAD-1:0]                row_pad;
   logic [PAD-1:0]                mask;
   logic [PAD-1:0]                row_new;
   logic [pcivt_pkg::FFV_W-1:0]   start;
   logic [NG-1:0]                 group_any;
   logic [GRP_AW-1:0]             grp;
   logic [GB-1:0]                 grp_bits;
   logic [BIT_AW-1:0]             bitsel;
   logic [GNT_W-1:0]              grant_idx;
   logic [7:0]                    grant_wide;
   logic                          grant_ok;
   logic                          cpu_ok;
   logic                          ocpu_ok;
   logic                          vec_ok;
   logic                          rd_en;
   logic [CPU_AW-1:0]             rd_addr;
   logic                          wr_en;
   logic [CPU_AW-1:0]             wr_addr;
   logic [HT_AW-1:0]              hw_addr;
   logic [HT_AW-1:0]              hr_addr;
   pcivt_pkg::action_type         disp_action;
   logic [pcivt_pkg::ID_W-1:0]    disp_found;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff       <= req_command;
         cpu_ff       <= req_cpu;
         hid_ff       <= req_handler_id;
         vec_ff       <= req_vector;
         old_cpu_ff   <= req_old_cpu;
         old_valid_ff <= req_old_valid;
         priv_ff      <= req_privilege;
      end
   end

   assign cpu_ok  = {1'b0, cpu_ff} < 9'(CPU_COUNT);
   assign ocpu_ok = {1'b0, old_cpu_ff} < 9'(CPU_COUNT);
   assign vec_ok  = {1'b0, vec_ff} < 9'(VECTORS_PER_CPU);

   // rows never written since reset read as all free
   assign row_pad = rd_valid_ff ? PAD'(row_raw_ff) : '0;

   // ---- occupancy row memory
   assign rd_en   = ctl.load | ctl.old_read;
   assign rd_addr = ctl.load ? req_cpu[CPU_AW-1:0] : old_cpu_ff[CPU_AW-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cpu_ff[CPU_AW-1:0];
      row_new = row_pad;
      priority if (ctl.pick && grant_ok) begin
         wr_en              = 1'b1;
         row_new[grant_idx] = 1'b1;
      end else if (ctl.rel_cur && cpu_ok && vec_ok) begin
         wr_en                         = 1'b1;
         row_new[vec_ff[VEC_AW-1:0]] = 1'b0;
      end else if (ctl.old_clear && ocpu_ok && vec_ok) begin
         wr_en                         = 1'b1;
         wr_addr                       = old_cpu_ff[CPU_AW-1:0];
         row_new[vec_ff[VEC_AW-1:0]] = 1'b0;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         occ_mem[wr_addr] <= row_new[VECTORS_PER_CPU-1:0];
      end
      if (rd_en) begin
         row_raw_ff  <= occ_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OCC_DEPTH; i++) begin
            row_valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // ---- handler memory
   assign hw_addr = {cpu_ff[CPU_AW-1:0], grant_idx[VEC_AW-1:0]};
   assign hr_addr = {req_cpu[CPU_AW-1:0], req_vector[VEC_AW-1:0]};

   always_ff @(posedge clock) begin
      if (ctl.pick && grant_ok) begin
         hnd_mem[hw_addr] <= HANDLER_ID_BITS'(hid_ff);
      end
      if (ctl.load) begin
         hd_ff <= hnd_mem[hr_addr];
      end
   end

   // ---- free vector search: mask in scan, pick group then bit
   always_comb begin
      start = (first_free < pcivt_pkg::FFV_W'(pcivt_pkg::FIRST_IRQ_VECTOR))
            ? pcivt_pkg::FFV_W'(pcivt_pkg::FIRST_IRQ_VECTOR) : first_free;
      for (int i = 0; i < PAD; i++) begin
         mask[i] = (9'(i) >= {2'b00, start}) && (9'(i) < 9'(VECTORS_PER_CPU));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.scan) begin
         free_bits_ff <= ~row_pad & mask;
      end
   end

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         group_any[g] = |free_bits_ff[g*GB +: GB];
      end
      grp = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (group_any[g]) begin
            grp = GRP_AW'(g);
         end
      end
      grp_bits = free_bits_ff[grp*GB +: GB];
      bitsel   = '0;
      for (int b = GB - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            bitsel = BIT_AW'(b);
         end
      end
      grant_idx  = {grp, bitsel};
      grant_wide = 8'(grant_idx);
      grant_ok   = cpu_ok && (|group_any);
   end

   always_ff @(posedge clock) begin
      if (ctl.pick) begin
         ok_ff      <= grant_ok;
         granted_ff <= grant_ok ? grant_wide[pcivt_pkg::GRANT_W-1:0] : '0;
      end
   end

   // ---- dispatch classification
   always_comb begin
      disp_found = '0;
      priority if (vec_ff < 8'(pcivt_pkg::FIRST_IRQ_VECTOR)) begin
         disp_action = (priv_ff == 2'(pcivt_pkg::USER_PRIV) &&
                        vec_ff == 8'(pcivt_pkg::PAGE_FAULT_VECTOR))
                     ? pcivt_pkg::ACT_USER_PF : pcivt_pkg::ACT_FATAL;
      end else if (vec_ff == 8'(pcivt_pkg::TIMER_VECTOR)) begin
         disp_action = pcivt_pkg::ACT_TIMER;
      end else if (cpu_ok && vec_ok && row_pad[vec_ff[VEC_AW-1:0]]) begin
         disp_action = pcivt_pkg::ACT_HANDLER;
         disp_found  = pcivt_pkg::ID_W'(hd_ff);
      end else begin
         disp_action = pcivt_pkg::ACT_UNHANDLED;
      end
   end

   // ---- output register
   assign rsp_valid_in = ctl.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         unique case (cmd_ff)
            pcivt_pkg::CMD_ALLOC,
            pcivt_pkg::CMD_MOVE: begin
               rsp_ok_ff      <= ok_ff;
               rsp_granted_ff <= granted_ff;
               rsp_found_ff   <= '0;
               rsp_action_ff  <= pcivt_pkg::ACT_FATAL;
            end
            pcivt_pkg::CMD_FREE: begin
               rsp_ok_ff      <= 1'b0;
               rsp_granted_ff <= '0;
               rsp_found_ff   <= '0;
               rsp_action_ff  <= pcivt_pkg::ACT_FATAL;
            end
            default: begin
               rsp_ok_ff      <= 1'b0;
               rsp_granted_ff <= '0;
               rsp_found_ff   <= disp_found;
               rsp_action_ff  <= disp_action;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_granted_vector = rsp_granted_ff;
   assign rsp_found_handler  = rsp_found_ff;
   assign rsp_action         = rsp_action_ff;

   assign sts.cmd       = cmd_ff;
   assign sts.grant_ok  = grant_ok;
   assign sts.old_valid = old_valid_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule
